// File: hdl/rtkv_pkg.sv
`timescale 1ns / 1ps

package rtkv_pkg;

    // Field widths of the request and response beats.
    localparam int CMD_W = 2;
    localparam int KEY_W = 8;
    localparam int VAL_W = 8;
    localparam int CNT_OUT_W = 5;

    // Command codes carried in the request beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_LOOKUP = 2'd3
    } rtkv_cmd_t;

endpackage

// File: hdl/rtkv_req_if.sv
`timescale 1ns / 1ps

interface rtkv_req_if
    import rtkv_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] device_addr;
    logic [VAL_W-1:0] link_addr;

    modport source (output valid, output cmd, output device_addr, output link_addr,
                    input ready);
    modport sink   (input valid, input cmd, input device_addr, input link_addr,
                    output ready);
endinterface

// File: hdl/rtkv_rsp_if.sv
`timescale 1ns / 1ps

interface rtkv_rsp_if
    import rtkv_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [VAL_W-1:0]     found_value;
    logic [CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output ok, output found_value, output entry_count,
                    input ready);
    modport sink   (input valid, input ok, input found_value, input entry_count,
                    output ready);
endinterface

// File: hdl/route_table_key_value.sv
`timescale 1ns / 1ps

// Small associative table from device address to link address.
// Channel req carries one command per beat (add or update, remove, clear,
// lookup); channel rsp returns one beat per command with ok, found_value
// and entry_count. Both use valid/ready; a beat moves when both are high.
// Commands are handled one at a time. The entries sit in one synchronous
// memory with a registered read, and a command scans the live entries one
// per cycle; remove then reads the last entry and moves it into the freed
// slot. req.ready is high whenever no command is in progress, so the next
// command can start while a response still waits in the output register.
// If rsp stalls, a finished command holds until the output register frees.
// Reset empties the table (entry count zero) and drops any pending beat;
// the memory contents need no clearing since only live slots are read.
module route_table_key_value
    import rtkv_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    rtkv_req_if.sink   req,
    rtkv_rsp_if.source rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = KEY_W + VAL_W;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_MOVE_RD = 5'b00100,
        ST_MOVE_WR = 5'b01000,
        ST_FINISH  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    rtkv_cmd_t            cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_ptr_reg, scan_ptr_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 res_ok_reg, res_ok_next;
    logic [VAL_W-1:0]     res_val_reg, res_val_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 out_ok_reg, out_ok_next;
    logic [VAL_W-1:0]     out_val_reg, out_val_next;
    logic [CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;

    // Entry memory: key in the upper byte, value in the lower byte.
    logic [ENT_W-1:0]     mem [TABLE_DEPTH];
    logic [ENT_W-1:0]     mem_rd_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;

    logic                 issue;
    logic                 hit;
    logic [CNT_W-1:0]     last_cnt;
    logic [IDX_W-1:0]     last_idx;
    logic [CNT_W+CNT_OUT_W-1:0] count_wide;

    assign issue      = scan_ptr_reg < count_reg;
    assign hit        = rd_vld_reg && (mem_rd_reg[ENT_W-1:VAL_W] == key_reg);
    assign last_cnt   = count_reg - CNT_W'(1);
    assign last_idx   = last_cnt[IDX_W-1:0];
    assign count_wide = {{CNT_OUT_W{1'b0}}, count_reg};

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_vld_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.found_value = out_val_reg;
    assign rsp.entry_count = out_cnt_reg;

    // Memory port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_raddr];
        end
    end

    // Command sequencer: clear at once or scan, modify and write back, then hand off the result.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        slot_next     = slot_reg;
        res_ok_next   = res_ok_reg;
        res_val_next  = res_val_reg;
        out_vld_next  = out_vld_reg;
        out_ok_next   = out_ok_reg;
        out_val_next  = out_val_reg;
        out_cnt_next  = out_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = rd_idx_reg;
        mem_wdata     = {key_reg, val_reg};
        mem_re        = 1'b0;
        mem_raddr     = scan_ptr_reg[IDX_W-1:0];

        // The output register empties when the receiver takes the beat.
        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = rtkv_cmd_t'(req.cmd);
                    key_next      = req.device_addr;
                    val_next      = req.link_addr;
                    scan_ptr_next = '0;
                    res_ok_next   = 1'b0;
                    res_val_next  = '0;
                    if (rtkv_cmd_t'(req.cmd) == CMD_CLEAR)
                    begin
                        count_next  = '0;
                        res_ok_next = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Keep one read in flight per cycle while live slots remain.
                if (issue)
                begin
                    mem_re        = 1'b1;
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_ptr_reg[IDX_W-1:0];
                    scan_ptr_next = scan_ptr_reg + CNT_W'(1);
                end

                if (hit)
                begin
                    res_ok_next = 1'b1;
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = rd_idx_reg;
                            state_next = ST_FINISH;
                        end
                        CMD_REMOVE:
                        begin
                            slot_next  = rd_idx_reg;
                            state_next = ST_MOVE_RD;
                        end
                        CMD_LOOKUP:
                        begin
                            res_val_next = mem_rd_reg[VAL_W-1:0];
                            state_next   = ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
                else if (!issue && !rd_vld_reg)
                begin
                    // Key absent: only an add may still append it.
                    if ((cmd_reg == CMD_ADD) && (count_reg < CNT_W'(TABLE_DEPTH)))
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = count_reg[IDX_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                        res_ok_next = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_MOVE_RD:
            begin
                // Fetch the last entry so it can fill the freed slot.
                mem_re     = 1'b1;
                mem_raddr  = last_idx;
                state_next = ST_MOVE_WR;
            end

            ST_MOVE_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_reg;
                mem_wdata  = mem_rd_reg;
                count_next = last_cnt;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next = 1'b1;
                    out_ok_next  = res_ok_reg;
                    out_val_next = res_val_reg;
                    out_cnt_next = count_wide[CNT_OUT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        scan_ptr_reg <= scan_ptr_next;
        rd_idx_reg   <= rd_idx_next;
        slot_reg     <= slot_next;
        res_ok_reg   <= res_ok_next;
        res_val_reg  <= res_val_next;
        out_ok_reg   <= out_ok_next;
        out_val_reg  <= out_val_next;
        out_cnt_reg  <= out_cnt_next;
    end

endmodule
